FILE: hw/rtl/prld_pkg.sv
// shared types and constants for the pixel run-length decoder
package prld_pkg;

  // decode phase of the front end
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_RUN     = 3'd1,
    PH_LITERAL = 3'd2,
    PH_DONE    = 3'd3,
    PH_ERROR   = 3'd4
  } prld_phase_e;

  // end-of-tile status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRUNC    = 2'd1;
  localparam logic [1:0] ST_OVERRUN  = 2'd2;
  localparam logic [1:0] ST_TRAILING = 2'd3;

  // result kinds
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // header byte layout
  localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
  localparam int unsigned HDR_RUN_BIT   = 7;
  localparam logic [1:0] LAST_SLOT      = 2'd3;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);

  // one queue entry: an optional pixel group and an optional status
  typedef struct packed {
    logic        pix_vld;
    logic [31:0] pixel;
    logic [7:0]  count;
    logic [11:0] index;
    logic        stat_vld;
    logic [1:0]  status;
  } prld_entry_t;

  // queue state seen by the front end
  typedef struct packed {
    logic full;
  } prld_qstat_t;

endpackage

FILE: hw/rtl/prld_front.sv
// front end: takes payload bytes, tracks packets and builds queue entries
module prld_front import prld_pkg::*; #(
  parameter int TILE_PIXELS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  prld_qstat_t qstat_i,
  output logic        push_o,
  output prld_entry_t entry_o
);

  localparam int DW = $clog2(TILE_PIXELS + 1);
  localparam int EW = ((DW > 12) ? DW : 12) + 1;
  localparam logic [EW-1:0] TILE_EXT = EW'(TILE_PIXELS);

  prld_phase_e phase_q, phase_d;
  logic [7:0]  rem_q, rem_d;
  logic [1:0]  slot_q, slot_d;
  logic [23:0] partial_q, partial_d;
  logic [DW-1:0] done_q, done_d;
  logic [1:0]  err_q, err_d;

  logic          accept;
  logic [7:0]    hdr_count;
  logic [7:0]    cnt;
  logic [EW-1:0] done_ext;

  assign accept   = valid_i && !qstat_i.full;
  assign ready_o  = !qstat_i.full;
  assign done_ext = EW'(done_q);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      rem_q     <= '0;
      slot_q    <= '0;
      partial_q <= '0;
      done_q    <= '0;
      err_q     <= ST_OK;
    end else begin
      phase_q   <= phase_d;
      rem_q     <= rem_d;
      slot_q    <= slot_d;
      partial_q <= partial_d;
      done_q    <= done_d;
      err_q     <= err_d;
    end
  end

  // byte decode, next state and entry build
  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    slot_d    = slot_q;
    partial_d = partial_q;
    done_d    = done_q;
    err_d     = err_q;
    hdr_count = (byte_i & HDR_COUNT_MASK) + 8'd1;
    cnt       = (phase_q == PH_RUN) ? rem_q : 8'd1;

    entry_o          = '0;
    entry_o.pixel    = {byte_i, partial_q};
    entry_o.count    = cnt;
    entry_o.index    = done_ext[11:0];

    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          if (EW'(hdr_count) + done_ext > TILE_EXT) begin
            err_d   = ST_OVERRUN;
            phase_d = PH_ERROR;
          end else begin
            rem_d     = hdr_count;
            slot_d    = '0;
            partial_d = '0;
            phase_d   = byte_i[HDR_RUN_BIT] ? PH_RUN : PH_LITERAL;
          end
        end
        PH_RUN, PH_LITERAL: begin
          if (slot_q != LAST_SLOT) begin
            case (slot_q)
              2'd0:    partial_d[7:0]   = byte_i;
              2'd1:    partial_d[15:8]  = byte_i;
              default: partial_d[23:16] = byte_i;
            endcase
            slot_d = slot_q + 2'd1;
          end else begin
            entry_o.pix_vld = 1'b1;
            done_d    = done_q + DW'(cnt);
            rem_d     = rem_q - cnt;
            slot_d    = '0;
            partial_d = '0;
            if (rem_d == 8'd0) begin
              phase_d = (EW'(done_d) >= TILE_EXT) ? PH_DONE : PH_HEADER;
            end
          end
        end
        PH_DONE: begin
          err_d   = ST_TRAILING;
          phase_d = PH_ERROR;
        end
        default: begin
          // error drain: byte ignored
        end
      endcase

      // end of payload: status, then rearm
      if (last_i) begin
        entry_o.stat_vld = 1'b1;
        entry_o.status   = (err_d != ST_OK) ? err_d :
                           ((phase_d == PH_DONE) ? ST_OK : ST_TRUNC);
        phase_d   = PH_HEADER;
        rem_d     = '0;
        slot_d    = '0;
        partial_d = '0;
        done_d    = '0;
        err_d     = ST_OK;
      end
    end
  end

  assign push_o = accept && (entry_o.pix_vld || entry_o.stat_vld);

endmodule

FILE: hw/rtl/prld_queue.sv
// short entry queue between the front end and the back end
module prld_queue import prld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  prld_entry_t entry_i,
  input  logic        pop_i,
  output logic        nempty_o,
  output prld_entry_t head_o,
  output prld_qstat_t qstat_o
);

  prld_entry_t mem_q [QDEPTH];
  logic [QPW-1:0] wptr_q, rptr_q;
  logic [QPW:0]   fill_q;
  logic           do_push, do_pop;

  assign do_push = push_i && (fill_q != (QPW+1)'(QDEPTH));
  assign do_pop  = pop_i && (fill_q != '0);

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      fill_q <= fill_q + (QPW+1)'(do_push) - (QPW+1)'(do_pop);
    end
  end

  assign head_o       = mem_q[rptr_q];
  assign nempty_o     = (fill_q != '0);
  assign qstat_o.full = (fill_q == (QPW+1)'(QDEPTH));

endmodule

FILE: hw/rtl/prld_back.sv
// back end: output register that sends an entry's pixel group, if any, and then its status, if any
module prld_back import prld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        nempty_i,
  input  prld_entry_t head_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        kind_o,
  output logic [31:0] pixel_o,
  output logic [7:0]  count_o,
  output logic [11:0] index_o,
  output logic [1:0]  status_o,
  output logic        final_o
);

  prld_entry_t cur_q;
  logic        cur_vld_q;
  logic        hs, two;

  assign hs    = valid_o && ready_i;
  assign two   = cur_q.pix_vld && cur_q.stat_vld;
  assign pop_o = nempty_i && (!cur_vld_q || (hs && !two));

  // current entry register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
    end else if (!cur_vld_q || (hs && !two)) begin
      cur_vld_q <= nempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end else if (hs && two) begin
      cur_q.pix_vld <= 1'b0;
    end
  end

  // result selection: pixel group first
  always_comb begin
    valid_o = cur_vld_q;
    if (cur_q.pix_vld) begin
      kind_o   = KIND_PIXEL;
      pixel_o  = cur_q.pixel;
      count_o  = cur_q.count;
      index_o  = cur_q.index;
      status_o = ST_OK;
      final_o  = !cur_q.stat_vld;
    end else begin
      kind_o   = KIND_STATUS;
      pixel_o  = '0;
      count_o  = '0;
      index_o  = '0;
      status_o = cur_q.status;
      final_o  = 1'b1;
    end
  end

endmodule

FILE: hw/rtl/pixel_run_length_decoder.sv
// top level of the pixel run-length decoder
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata = data_byte, tlast = end_of_payload
//  m_axis    out  m_axis_tvalid/tready        tdata, tuser = result_kind,
//                                             tlast = final_result
//
// one byte is taken each cycle while the four-entry queue has room; the
// front end decodes it in that cycle. the back end sends one result per
// cycle from its output register while m_axis_tready is high, so a byte that
// gives a pixel group and a status yields two results, the pixel group first.
// reset is asynchronous, active low, and puts the decoder at a tile start.
// either side may stall freely; the queue absorbs the difference.
module pixel_run_length_decoder import prld_pkg::*; #(
  parameter int TILE_PIXELS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte [7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_value [31:0], repeat_count [39:32], first_index [51:40],
  // decode_status [53:52], zero [55:54]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser,   // result_kind [0]
  output logic        m_axis_tlast
);

  prld_entry_t push_entry, head;
  prld_qstat_t qstat;
  logic        push, pop, nempty;
  logic [31:0] pixel;
  logic [7:0]  count;
  logic [11:0] index;
  logic [1:0]  status;

  // byte decode
  prld_front #(.TILE_PIXELS(TILE_PIXELS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .qstat_i (qstat),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // decoupling queue
  prld_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .nempty_o (nempty),
    .head_o   (head),
    .qstat_o  (qstat)
  );

  // result output
  prld_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .nempty_i (nempty),
    .head_i   (head),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .kind_o   (m_axis_tuser),
    .pixel_o  (pixel),
    .count_o  (count),
    .index_o  (index),
    .status_o (status),
    .final_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, status, index, count, pixel};

endmodule
